// ===== design/gla_pkg.sv =====
package gla_pkg;

	// canvas geometry
	localparam int MAX_CANVAS_WIDTH  = 128;
	localparam int MAX_CANVAS_HEIGHT = 128;
	localparam int CANVAS_DEPTH      = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
	localparam int CANVAS_AW         = $clog2(CANVAS_DEPTH);

	// register and field widths
	localparam int CFG_W   = 8;
	localparam int CH_W    = 8;
	localparam int PIX_W   = 4 * CH_W;
	localparam int DEN_W   = 16;
	localparam int NUM_W   = 24;
	localparam int COORD_W = 13;

	// width holding a saturated canvas dimension (at least the register width)
	localparam int DIM_WX = $clog2(MAX_CANVAS_WIDTH + 1);
	localparam int DIM_WY = $clog2(MAX_CANVAS_HEIGHT + 1);
	localparam int DIM_WM = (DIM_WX > DIM_WY) ? DIM_WX : DIM_WY;
	localparam int DIM_W  = (DIM_WM > CFG_W) ? DIM_WM : CFG_W;

	// operation codes
	localparam logic [1:0] OP_BLEND = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(64);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(64);

	// divisor for the alpha quotient
	localparam logic [DEN_W-1:0] FULL_SCALE = DEN_W'(255);

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] quo;
	} div_sts_t;

	typedef struct packed {
		logic                 rd;
		logic                 wr;
		logic [CANVAS_AW-1:0] addr;
		logic [PIX_W-1:0]     wdata;
	} cv_req_t;

endpackage

// ===== design/glyph_layer_alpha_compositor.sv =====
// Layer compositor into an on-chip 128x128 BGRA canvas (32-bit words: blue in
// the low byte, then green, red, alpha). Each input word is a blend, read or
// clear of one pixel at (start_x + pixel_x, start_y + pixel_y) and gives
// exactly one output word: the pixel after the operation with in_bounds set,
// or all zero with in_bounds clear when the destination falls outside the
// canvas_width x canvas_height window (registers saturate at 128; a size of 0
// clips everything). Blend is straight-alpha "over" with coverage as source
// alpha, floored integer math; a fully transparent source over a transparent
// pixel leaves it unchanged. Operation code 3 behaves as a read. After reset
// the canvas is swept to zero, during which s_axis_tready stays low;
// configuration writes are taken at any time but should only be issued while
// no word is in flight. Items are processed one at a time: a read, a clear or a
// clipped word goes through address calculation and the canvas read to the
// output register; a blend also multiplies out and sets up its denominator,
// and unless source and stored pixel are both transparent it then runs the
// shared radix-4 divider once for each of the four quotients (blue, green,
// red, alpha), each after its own multiplies. The next word is accepted the
// cycle after the output register loads, even while that result still waits
// there.
module glyph_layer_alpha_compositor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x[11:0], start_y[23:12], pixel_x[31:24], pixel_y[39:32],
	// coverage[47:40], color_red[55:48], color_green[63:56], color_blue[71:64]
	input  logic [71:0] s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_blue[7:0], out_green[15:8], out_red[23:16], out_alpha[31:24]
	output logic [31:0] m_axis_tdata,
	// in_bounds[0]
	output logic [0:0]  m_axis_tuser,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CALC = 10'b0000000010,
		ST_RD   = 10'b0000000100,
		ST_PIX  = 10'b0000001000,
		ST_TMUL = 10'b0000010000,
		ST_DEN  = 10'b0000100000,
		ST_MUL  = 10'b0001000000,
		ST_NUM  = 10'b0010000000,
		ST_DIV  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	localparam int CH  = gla_pkg::CH_W;
	localparam int DW  = gla_pkg::DIM_W;
	localparam int CW  = gla_pkg::COORD_W;
	localparam int AW  = gla_pkg::CANVAS_AW;

	state_t state_q;

	// configuration
	logic [gla_pkg::CFG_W-1:0] width_q;
	logic [gla_pkg::CFG_W-1:0] height_q;
	logic [DW-1:0]             w_eff;
	logic [DW-1:0]             h_eff;

	// captured word
	logic [1:0]    op_q;
	logic [11:0]   sx_q;
	logic [11:0]   sy_q;
	logic [CH-1:0] px_q;
	logic [CH-1:0] py_q;
	logic [CH-1:0] cov_q;
	logic [CH-1:0] col_q [3];   // blue, green, red

	// datapath
	logic signed [CW-1:0]       dx;
	logic signed [CW-1:0]       dy;
	logic                       dx_in;
	logic                       dy_in;
	logic [AW-1:0]              addr_q;
	logic                       inb_q;
	logic [gla_pkg::DEN_W-1:0]  t_q;     // d * (255 - c)
	logic [gla_pkg::DEN_W-1:0]  den_q;   // 255 c + d (255 - c)
	logic [2*CH-1:0]            p1_q;    // col * c
	logic [gla_pkg::NUM_W-1:0]  p2_q;    // old * t
	logic [1:0]                 ch_q;    // 0..2 colour, 3 alpha
	logic [gla_pkg::PIX_W-1:0]  res_q;
	logic                       rinb_q;
	logic [CH-1:0]              old_ch;
	logic [CH-1:0]              cur_col;
	logic [CH-1:0]              dst_a;

	logic [gla_pkg::PIX_W-1:0] pix;
	logic                      cv_ready;
	gla_pkg::cv_req_t          cv_req;
	gla_pkg::div_req_t         div_req;
	gla_pkg::div_sts_t         div_sts;

	logic s_acc;
	logic out_load;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gla_pkg::WIDTH_RST;
			height_q <= gla_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gla_pkg::REG_WIDTH:  width_q  <= cfg_data;
				gla_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// oversized registers clamp to the physical canvas
	assign w_eff = (DW'(width_q) > DW'(gla_pkg::MAX_CANVAS_WIDTH)) ?
		DW'(gla_pkg::MAX_CANVAS_WIDTH) : DW'(width_q);
	assign h_eff = (DW'(height_q) > DW'(gla_pkg::MAX_CANVAS_HEIGHT)) ?
		DW'(gla_pkg::MAX_CANVAS_HEIGHT) : DW'(height_q);

	// ---------------------------------------------------------------- input
	assign s_axis_tready = (state_q == ST_IDLE) & cv_ready;
	assign s_acc         = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= s_axis_tuser;
			sx_q     <= s_axis_tdata[11:0];
			sy_q     <= s_axis_tdata[23:12];
			px_q     <= s_axis_tdata[31:24];
			py_q     <= s_axis_tdata[39:32];
			cov_q    <= s_axis_tdata[47:40];
			col_q[2] <= s_axis_tdata[55:48];
			col_q[1] <= s_axis_tdata[63:56];
			col_q[0] <= s_axis_tdata[71:64];
		end
	end

	// destination: signed offset plus unsigned bitmap position
	assign dx = CW'($signed(sx_q)) + $signed({{(CW-CH){1'b0}}, px_q});
	assign dy = CW'($signed(sy_q)) + $signed({{(CW-CH){1'b0}}, py_q});
	assign dx_in = ~dx[CW-1] & ($unsigned(dx) < CW'(w_eff));
	assign dy_in = ~dy[CW-1] & ($unsigned(dy) < CW'(h_eff));

	// ---------------------------------------------------------------- shared units
	gla_canvas u_canvas (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cv_req),
		.rdata  (pix),
		.ready  (cv_ready)
	);

	gla_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	assign old_ch  = pix[ch_q*CH +: CH];
	assign cur_col = col_q[(ch_q == 2'd3) ? 2'd0 : ch_q];
	assign dst_a   = pix[3*CH +: CH];

	always_comb begin
		cv_req       = '0;
		cv_req.addr  = addr_q;
		cv_req.rd    = (state_q == ST_RD);
		div_req      = '0;
		div_req.start = (state_q == ST_NUM);
		if (ch_q == 2'd3) begin
			div_req.num = gla_pkg::NUM_W'(den_q);
			div_req.den = gla_pkg::FULL_SCALE;
		end else begin
			// col*255*c + old*d*(255-c)
			div_req.num = (gla_pkg::NUM_W'(p1_q) << CH) - gla_pkg::NUM_W'(p1_q) + p2_q;
			div_req.den = den_q;
		end
		if (state_q == ST_PIX && inb_q && op_q == gla_pkg::OP_CLEAR) begin
			cv_req.wr    = 1'b1;
			cv_req.wdata = '0;
		end else if (state_q == ST_DIV && div_sts.done && ch_q == 2'd3) begin
			cv_req.wr    = 1'b1;
			cv_req.wdata = {div_sts.quo, res_q[3*CH-1:0]};
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign out_load = (state_q == ST_OUT) & (~m_axis_tvalid | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_acc) state_q <= ST_CALC;
				ST_CALC: state_q <= ST_RD;
				ST_RD:   state_q <= ST_PIX;
				ST_PIX: begin
					if (inb_q && op_q == gla_pkg::OP_BLEND) begin
						state_q <= ST_TMUL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_TMUL: state_q <= ST_DEN;
				ST_DEN: begin
					// transparent over transparent: pixel stays as read
					if (cov_q == '0 && dst_a == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_NUM;
				ST_NUM: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= (ch_q == 2'd3) ? ST_OUT : ST_MUL;
					end
				end
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (state_q == ST_DEN) begin
			ch_q <= '0;
		end else if (state_q == ST_DIV && div_sts.done) begin
			ch_q <= ch_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CALC: begin
				inb_q  <= dx_in & dy_in;
				addr_q <= AW'(dy[DW-1:0]) * AW'(w_eff) + AW'(dx[DW-1:0]);
			end
			ST_PIX: begin
				rinb_q <= inb_q;
				if (!inb_q || op_q == gla_pkg::OP_CLEAR) begin
					res_q <= '0;
				end else begin
					res_q <= pix;
				end
			end
			ST_TMUL: begin
				t_q <= gla_pkg::DEN_W'(dst_a) *
					(gla_pkg::FULL_SCALE - gla_pkg::DEN_W'(cov_q));
			end
			ST_DEN: begin
				den_q <= (gla_pkg::DEN_W'(cov_q) << CH) - gla_pkg::DEN_W'(cov_q) + t_q;
			end
			ST_MUL: begin
				p1_q <= (2*CH)'(cur_col) * (2*CH)'(cov_q);
				p2_q <= gla_pkg::NUM_W'(old_ch) * gla_pkg::NUM_W'(t_q);
			end
			ST_DIV: if (div_sts.done) res_q[ch_q*CH +: CH] <= div_sts.quo;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata    <= res_q;
			m_axis_tuser[0] <= rinb_q;
		end
	end

endmodule

// ===== design/gla_div.sv =====
// radix-4 restoring divider, 8-bit quotient; caller guarantees num < 256 * den
module gla_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gla_pkg::div_req_t req,
	output gla_pkg::div_sts_t sts
);

	logic [gla_pkg::NUM_W-1:0] rem_q;
	logic [gla_pkg::NUM_W-1:0] d1_q;
	logic [gla_pkg::NUM_W-1:0] d2_q;
	logic [gla_pkg::NUM_W-1:0] d3_q;
	logic [gla_pkg::CH_W-1:0]  quo_q;
	logic [1:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [1:0]                digit;
	logic [gla_pkg::NUM_W-1:0] rem_nxt;
	logic [gla_pkg::NUM_W-1:0] den_x;

	assign den_x = gla_pkg::NUM_W'(req.den);

	always_comb begin
		priority if (rem_q >= d3_q) begin
			digit   = 2'd3;
			rem_nxt = rem_q - d3_q;
		end else if (rem_q >= d2_q) begin
			digit   = 2'd2;
			rem_nxt = rem_q - d2_q;
		end else if (rem_q >= d1_q) begin
			digit   = 2'd1;
			rem_nxt = rem_q - d1_q;
		end else begin
			digit   = 2'd0;
			rem_nxt = rem_q;
		end
	end

	// datapath: divisor multiples start shifted up by 6 and walk down 2 bits a step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			d1_q  <= den_x << 6;
			d2_q  <= den_x << 7;
			d3_q  <= (den_x << 6) + (den_x << 7);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			d1_q  <= d1_q >> 2;
			d2_q  <= d2_q >> 2;
			d3_q  <= d3_q >> 2;
			quo_q <= {quo_q[gla_pkg::CH_W-3:0], digit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd3;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 2'd1;
				if (cnt_q == 2'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.quo  = quo_q;

endmodule

// ===== design/gla_canvas.sv =====
// canvas pixel memory, one port, registered read; zeroed by a sweep after reset
module gla_canvas (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gla_pkg::cv_req_t           req,
	output logic [gla_pkg::PIX_W-1:0]  rdata,
	output logic                       ready
);

	logic [gla_pkg::PIX_W-1:0]     mem [gla_pkg::CANVAS_DEPTH];
	logic [gla_pkg::PIX_W-1:0]     rdata_q;
	logic [gla_pkg::CANVAS_AW-1:0] clr_q;
	logic                          clr_busy_q;
	logic                          we;
	logic [gla_pkg::CANVAS_AW-1:0] wa;
	logic [gla_pkg::PIX_W-1:0]     wd;

	assign we = clr_busy_q | req.wr;
	assign wa = clr_busy_q ? clr_q : req.addr;
	assign wd = clr_busy_q ? '0 : req.wdata;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + gla_pkg::CANVAS_AW'(1);
			if (clr_q == gla_pkg::CANVAS_AW'(gla_pkg::CANVAS_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign ready = ~clr_busy_q;

endmodule
